/* design/gpiolk_pkg.sv */
// Shared types and constants for the GPIO port with configuration lock.
// Used by gpiolk_lock, gpiolk_regs and gpio_port_with_lock_sequence.
// No dependencies.
`default_nettype none

package gpiolk_pkg;

    // Port geometry
    localparam int PIN_COUNT     = 16;
    localparam int PIN_W         = 16;
    localparam int DATA_W        = 32;
    localparam int NIBBLE_W      = 4;
    localparam int PINS_PER_WORD = 8;
    localparam int KEY_BIT       = 16;

    localparam logic [PIN_W-1:0]  PIN_MASK  = PIN_W'((33'd1 << PIN_COUNT) - 33'd1);
    localparam logic [DATA_W-1:0] CFG_RESET = 32'h4444_4444;

    // Access kind
    typedef enum logic
    {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    // Register map
    typedef enum logic [2:0]
    {
        SEL_CFG_LOW  = 3'd0,
        SEL_CFG_HIGH = 3'd1,
        SEL_INPUT    = 3'd2,
        SEL_OUTPUT   = 3'd3,
        SEL_SET_RST  = 3'd4,
        SEL_RESET    = 3'd5,
        SEL_LOCK     = 3'd6
    } reg_sel_t;

    // One bus access as held in the input register
    typedef struct packed
    {
        logic              cmd;
        logic [2:0]        sel;
        logic [DATA_W-1:0] wdata;
        logic [PIN_W-1:0]  levels;
    } access_t;

    // Request into the lock sequencer
    typedef struct packed
    {
        logic             rd;
        logic             wr;
        logic             key;
        logic [PIN_W-1:0] pattern;
    } lock_req_t;

    // Lock register contents
    typedef struct packed
    {
        logic             key;
        logic [PIN_W-1:0] bits;
    } lock_stat_t;

endpackage

`default_nettype wire

/* design/gpiolk_lock.sv */
// Lock register and key sequencer of the GPIO port.
// Depends on gpiolk_pkg.
`default_nettype none

module gpiolk_lock
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  gpiolk_pkg::lock_req_t       req,
    output gpiolk_pkg::lock_stat_t      stat,
    output gpiolk_pkg::lock_stat_t      stat_next
);
    import gpiolk_pkg::*;

    typedef enum logic [1:0]
    {
        STEP_IDLE,
        STEP_ARMED,
        STEP_CONFIRM,
        STEP_READY
    } step_t;

    step_t            step_reg;
    step_t            step_next;
    logic [PIN_W-1:0] pattern_reg;
    logic [PIN_W-1:0] pattern_next;
    logic [PIN_W-1:0] bits_reg;
    logic [PIN_W-1:0] bits_next;
    logic             key_reg;
    logic             key_next;
    logic [PIN_W-1:0] pat;
    logic             same;

    assign pat  = req.pattern & PIN_MASK;
    assign same = (pat == pattern_reg);

    // Advance the key sequence; an out-of-order write re-arms it (key set) or drops it, and a read ends it
    always_comb
    begin
        step_next    = step_reg;
        pattern_next = pattern_reg;
        bits_next    = bits_reg;
        key_next     = key_reg;
        if (req.wr && !key_reg)
        begin
            bits_next = pat;
            if (step_reg == STEP_ARMED && !req.key && same)
            begin
                step_next = STEP_CONFIRM;
            end
            else if (step_reg == STEP_CONFIRM && req.key && same)
            begin
                step_next = STEP_READY;
            end
            else if (req.key)
            begin
                step_next    = STEP_ARMED;
                pattern_next = pat;
            end
            else
            begin
                step_next = STEP_IDLE;
            end
        end
        if (req.rd && !key_reg)
        begin
            if (step_reg == STEP_READY)
            begin
                key_next = 1'b1;
            end
            step_next = STEP_IDLE;
        end
    end

    // Hold sequencer state and lock contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= STEP_IDLE;
            pattern_reg <= '0;
            bits_reg    <= '0;
            key_reg     <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            pattern_reg <= pattern_next;
            bits_reg    <= bits_next;
            key_reg     <= key_next;
        end
    end

    assign stat.key       = key_reg;
    assign stat.bits      = bits_reg;
    assign stat_next.key  = key_next;
    assign stat_next.bits = bits_next;

endmodule

`default_nettype wire

/* design/gpiolk_regs.sv */
// Configuration and output data registers of the GPIO port, with read mux.
// Depends on gpiolk_pkg; takes lock status from gpiolk_lock.
`default_nettype none

module gpiolk_regs
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  gpiolk_pkg::access_t                acc,
    input  gpiolk_pkg::lock_stat_t             lock,
    output logic [gpiolk_pkg::DATA_W-1:0]      read_data,
    output logic [gpiolk_pkg::PIN_W-1:0]       pins_next
);
    import gpiolk_pkg::*;

    logic [DATA_W-1:0] cfg_low_reg;
    logic [DATA_W-1:0] cfg_low_next;
    logic [DATA_W-1:0] cfg_high_reg;
    logic [DATA_W-1:0] cfg_high_next;
    logic [PIN_W-1:0]  out_reg;
    logic [DATA_W-1:0] keep_low;
    logic [DATA_W-1:0] keep_high;
    logic [PIN_W-1:0]  set_bits;
    logic [PIN_W-1:0]  clr_bits;

    assign set_bits = acc.wdata[PIN_W-1:0];
    assign clr_bits = acc.wdata[DATA_W-1:PIN_W];

    // Freeze the nibbles of locked pins once the key is active
    always_comb
    begin
        for (int i = 0; i < PINS_PER_WORD; i++)
        begin
            keep_low[NIBBLE_W*i +: NIBBLE_W]  = {NIBBLE_W{lock.key & lock.bits[i]}};
            keep_high[NIBBLE_W*i +: NIBBLE_W] =
                {NIBBLE_W{lock.key & lock.bits[i+PINS_PER_WORD]}};
        end
    end

    // Read-modify-write of the register selected by the access
    always_comb
    begin
        cfg_low_next  = cfg_low_reg;
        cfg_high_next = cfg_high_reg;
        pins_next     = out_reg;
        read_data     = '0;
        if (acc.cmd == CMD_READ)
        begin
            case (acc.sel)
                SEL_CFG_LOW:  read_data = cfg_low_reg;
                SEL_CFG_HIGH: read_data = cfg_high_reg;
                SEL_INPUT:    read_data = {{(DATA_W-PIN_W){1'b0}}, acc.levels & PIN_MASK};
                SEL_OUTPUT:   read_data = {{(DATA_W-PIN_W){1'b0}}, out_reg};
                SEL_LOCK:     read_data = {{(DATA_W-PIN_W-1){1'b0}}, lock.key, lock.bits};
                default:      read_data = '0;
            endcase
        end
        else
        begin
            case (acc.sel)
                SEL_CFG_LOW:
                begin
                    cfg_low_next = (cfg_low_reg & keep_low) | (acc.wdata & ~keep_low);
                end
                SEL_CFG_HIGH:
                begin
                    cfg_high_next = (cfg_high_reg & keep_high) | (acc.wdata & ~keep_high);
                end
                SEL_OUTPUT:  pins_next = set_bits & PIN_MASK;
                SEL_SET_RST: pins_next = ((out_reg & ~clr_bits) | set_bits) & PIN_MASK;
                SEL_RESET:   pins_next = out_reg & ~set_bits;
                default:     pins_next = out_reg;
            endcase
        end
    end

    // Commit register updates when the access passes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_low_reg  <= CFG_RESET;
            cfg_high_reg <= CFG_RESET;
            out_reg      <= '0;
        end
        else if (fire)
        begin
            cfg_low_reg  <= cfg_low_next;
            cfg_high_reg <= cfg_high_next;
            out_reg      <= pins_next;
        end
    end

endmodule

`default_nettype wire

/* design/gpio_port_with_lock_sequence.sv */
// Top level of the sixteen-pin GPIO port with configuration lock.
// Depends on gpiolk_pkg, gpiolk_regs and gpiolk_lock.
//
// Each input item is one register access (read or write); each produces exactly one
// result item carrying the read word, the output pin levels and the lock status after
// the access. The block takes one item per clock cycle while the output is not stalled;
// an item is held in the input register, passes through the read-modify-write logic,
// and lands in the result register, where it is offered until the output takes it.
// A stalled output holds the result while one more item waits in the input register.
// Once the lock key is active, the lock register and the configuration nibbles of
// locked pins are frozen until reset.
`default_nettype none

module gpio_port_with_lock_sequence
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // write_data[31:0], pin_levels[47:32]
    input  wire logic [3:0]  s_tuser,   // cmd[0], reg_select[3:1]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // read_data[31:0], pins_out[47:32], lock_active[48]
);
    import gpiolk_pkg::*;

    logic              in_valid_reg;
    access_t           acc_reg;
    logic              out_valid_reg;
    logic [55:0]       out_data_reg;
    logic              adv;
    lock_req_t         lock_req;
    lock_stat_t        lock_stat;
    lock_stat_t        lock_stat_next;
    logic [DATA_W-1:0] read_data;
    logic [PIN_W-1:0]  pins_next;

    // Move an item forward when the result register is free or being drained
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Route lock register accesses to the sequencer
    assign lock_req.rd      = adv && (acc_reg.cmd == CMD_READ) && (acc_reg.sel == SEL_LOCK);
    assign lock_req.wr      = adv && (acc_reg.cmd == CMD_WRITE) && (acc_reg.sel == SEL_LOCK);
    assign lock_req.key     = acc_reg.wdata[KEY_BIT];
    assign lock_req.pattern = acc_reg.wdata[PIN_W-1:0];

    gpiolk_lock u_lock
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (lock_req),
        .stat      (lock_stat),
        .stat_next (lock_stat_next)
    );

    gpiolk_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (adv),
        .acc       (acc_reg),
        .lock      (lock_stat),
        .read_data (read_data),
        .pins_next (pins_next)
    );

    // Input register: hold the accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            acc_reg.cmd    <= s_tuser[0];
            acc_reg.sel    <= s_tuser[3:1];
            acc_reg.wdata  <= s_tdata[31:0];
            acc_reg.levels <= s_tdata[47:32];
        end
    end

    // Result register: load on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {7'b0, lock_stat_next.key, pins_next, read_data};
        end
    end

    // Once active, the key never drops before reset
    a_key_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        lock_stat.key |=> lock_stat.key)
        else $error("lock key dropped while active");

    // Locked state freezes the lock pattern
    a_bits_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        lock_stat.key |=> $stable(lock_stat.bits))
        else $error("lock bits changed while key active");

    // A lock read with the key inactive reports the key bit as zero
    a_key_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (lock_req.rd && !lock_stat.key) |=> !m_tdata[KEY_BIT])
        else $error("lock read returned key set before activation");

    // Pin data above the pin count stays clear
    a_pin_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[47:32] & ~PIN_MASK) == '0))
        else $error("output pins beyond pin count set");

endmodule

`default_nettype wire
